FILE: rtl/core/gha_pkg.sv
package gha_pkg;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

endpackage

FILE: rtl/core/gha_ram.sv
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/generational_handle_allocator_unit.sv
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+------------------------------------------
// command   | in        | start & !busy              | i_opcode, i_handle_index, i_handle_generation
// result    | out       | o_valid, one cycle, no stall | o_status, o_new_index, o_new_generation,
//           |           |                            | o_live_count
//
// result appears the cycle after the last cycle of work on the item
// fresh-slot create, full create, out-of-range or unknown opcode: done in S_IDLE, busy stays low
// destroy and check in range: S_IDLE then S_CHK, one registered read of the slot memory
// create from the free stack: S_IDLE, S_POP, S_GEN, stack read then slot read in sequence
// synchronous active-low reset clears counters and control and holds busy high;
// memories are not cleared
// the receiver cannot stall; a new item may be taken in the cycle a result is shown
module generational_handle_allocator_unit #(
    parameter int SLOT_COUNT = 1024,
    parameter int GEN_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_opcode,
    input  logic [$clog2(SLOT_COUNT)-1:0]     i_handle_index,
    input  logic [GEN_BITS-1:0]               i_handle_generation,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic [$clog2(SLOT_COUNT)-1:0]     o_new_index,
    output logic [GEN_BITS-1:0]               o_new_generation,
    output logic [$clog2(SLOT_COUNT+1)-1:0]   o_live_count
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_W = GEN_BITS + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_GEN,
        S_CHK
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_op;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [GEN_BITS-1:0] r_gen;
    logic [CNT_W-1:0]  r_free_depth, n_free_depth;
    logic [CNT_W-1:0]  r_slots_used, n_slots_used;
    logic [CNT_W-1:0]  r_live_total, n_live_total;

    logic                r_valid, n_valid;
    logic [1:0]          r_status, n_status;
    logic [IDX_W-1:0]    r_new_index, n_new_index;
    logic [GEN_BITS-1:0] r_new_generation, n_new_generation;

    logic                slot_we;
    logic [IDX_W-1:0]    slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]   slot_wdata, slot_rdata;
    logic                stack_we;
    logic [IDX_W-1:0]    stack_waddr, stack_raddr;
    logic [IDX_W-1:0]    stack_wdata, stack_rdata;

    logic                accept;
    logic                slot_alive;
    logic [GEN_BITS-1:0] slot_gen;
    logic                handle_ok;
    logic [CNT_W-1:0]    free_top;

    gha_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdata(slot_wdata),
        .i_raddr(slot_raddr),
        .o_rdata(slot_rdata)
    );

    gha_ram #(
        .WIDTH(IDX_W),
        .DEPTH(SLOT_COUNT)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (stack_we),
        .i_waddr(stack_waddr),
        .i_wdata(stack_wdata),
        .i_raddr(stack_raddr),
        .o_rdata(stack_rdata)
    );

    assign busy       = (r_state != S_IDLE) || !i_rst_n;
    assign accept     = start && !busy;
    assign slot_alive = slot_rdata[SLOT_W-1];
    assign slot_gen   = slot_rdata[GEN_BITS-1:0];
    assign handle_ok  = slot_alive && (slot_gen == r_gen);
    assign free_top   = r_free_depth - CNT_W'(1);

    assign stack_raddr = free_top[IDX_W-1:0];
    assign slot_raddr  = (r_state == S_POP) ? stack_rdata : i_handle_index;

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        n_free_depth     = r_free_depth;
        n_slots_used     = r_slots_used;
        n_live_total     = r_live_total;
        n_valid          = 1'b0;
        n_status         = gha_pkg::ST_BAD;
        n_new_index      = '0;
        n_new_generation = '0;
        slot_we          = 1'b0;
        slot_waddr       = r_idx;
        slot_wdata       = '0;
        stack_we         = 1'b0;
        stack_waddr      = r_free_depth[IDX_W-1:0];
        stack_wdata      = r_idx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = i_handle_index;
                    case (i_opcode)
                        gha_pkg::OP_CREATE: begin
                            if (r_free_depth != '0) begin
                                n_state = S_POP;
                            end else if (r_slots_used < CNT_W'(SLOT_COUNT)) begin
                                slot_we          = 1'b1;
                                slot_waddr       = r_slots_used[IDX_W-1:0];
                                slot_wdata       = {1'b1, {GEN_BITS{1'b0}}};
                                n_slots_used     = r_slots_used + CNT_W'(1);
                                n_live_total     = r_live_total + CNT_W'(1);
                                n_valid          = 1'b1;
                                n_status         = gha_pkg::ST_OK;
                                n_new_index      = r_slots_used[IDX_W-1:0];
                            end else begin
                                n_valid  = 1'b1;
                                n_status = gha_pkg::ST_FULL;
                            end
                        end
                        gha_pkg::OP_DESTROY, gha_pkg::OP_CHECK: begin
                            if (CNT_W'(i_handle_index) < r_slots_used) begin
                                n_state = S_CHK;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_idx        = stack_rdata;
                n_free_depth = free_top;
                n_state      = S_GEN;
            end
            S_GEN: begin
                slot_we          = 1'b1;
                slot_wdata       = {1'b1, slot_gen};
                n_live_total     = r_live_total + CNT_W'(1);
                n_valid          = 1'b1;
                n_status         = gha_pkg::ST_OK;
                n_new_index      = r_idx;
                n_new_generation = slot_gen;
                n_state          = S_IDLE;
            end
            S_CHK: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (handle_ok) begin
                    n_status = gha_pkg::ST_OK;
                    if (r_op == gha_pkg::OP_DESTROY) begin
                        slot_we      = 1'b1;
                        slot_wdata   = {1'b0, GEN_BITS'(slot_gen + 1'b1)};
                        n_live_total = r_live_total - CNT_W'(1);
                        if (!(&slot_gen) && (r_free_depth < CNT_W'(SLOT_COUNT))) begin
                            stack_we     = 1'b1;
                            n_free_depth = r_free_depth + CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_depth <= '0;
            r_slots_used <= '0;
            r_live_total <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_depth <= n_free_depth;
            r_slots_used <= n_slots_used;
            r_live_total <= n_live_total;
            r_valid      <= n_valid;
        end
        if (accept) begin
            r_op  <= i_opcode;
            r_gen <= i_handle_generation;
        end
        r_idx            <= n_idx;
        r_status         <= n_status;
        r_new_index      <= n_new_index;
        r_new_generation <= n_new_generation;
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_new_index      = r_new_index;
    assign o_new_generation = r_new_generation;
    assign o_live_count     = r_live_total;

    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W + 1)'(r_live_total) + (CNT_W + 1)'(r_free_depth) <= (CNT_W + 1)'(r_slots_used))
        else $error("live plus free slots exceed slots taken");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_free_depth != '0))
        else $error("pop from empty free stack");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN || r_state == S_CHK) |=> (o_valid && r_state == S_IDLE))
        else $error("missing result after slot access");

endmodule

FILE: verif/generational_handle_allocator_unit_tb.sv
`timescale 1ns / 1ps

module generational_handle_allocator_unit_tb;

    localparam int SLOTS = 1024;
    localparam int GBITS = 16;
    localparam int IBITS = $clog2(SLOTS);
    localparam int LBITS = $clog2(SLOTS + 1);
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [GBITS-1:0] GEN_TOP = '1;
    localparam int RANDOM_ITEMS = 560;
    localparam int CYCLE_LIMIT = 40_000;

    typedef struct packed {
        logic [1:0]       status;
        logic [IBITS-1:0] index;
        logic [GBITS-1:0] generation;
        logic [LBITS-1:0] live;
    } t_answer;

    typedef struct packed {
        logic [IBITS-1:0] index;
        logic [GBITS-1:0] generation;
    } t_handle;

    class t_allocator_scoreboard;
        bit               alive[SLOTS];
        logic [GBITS-1:0] slot_gen[SLOTS];
        logic [IBITS-1:0] free_slots[SLOTS];
        int               free_depth;
        int               used;
        int               live;
        t_answer          pending[$];
        int               errors;

        function bit is_live(logic [IBITS-1:0] idx, logic [GBITS-1:0] g);
            if (idx >= used) return 1'b0;
            return alive[idx] && slot_gen[idx] == g;
        endfunction

        function t_answer note_item(logic [1:0] op, logic [IBITS-1:0] idx, logic [GBITS-1:0] g);
            t_answer a;
            int s;
            a = '0;
            a.status = gha_pkg::ST_BAD;
            case (op)
                gha_pkg::OP_CREATE: begin
                    s = -1;
                    if (free_depth > 0) begin
                        free_depth--;
                        s = free_slots[free_depth];
                    end else if (used < SLOTS) begin
                        s = used;
                        used++;
                        slot_gen[s] = '0;
                    end
                    if (s >= 0) begin
                        alive[s] = 1'b1;
                        live++;
                        a.status = gha_pkg::ST_OK;
                        a.index = s[IBITS-1:0];
                        a.generation = slot_gen[s];
                    end else begin
                        a.status = gha_pkg::ST_FULL;
                    end
                end
                gha_pkg::OP_DESTROY: begin
                    if (is_live(idx, g)) begin
                        alive[idx] = 1'b0;
                        live--;
                        // a slot at the last generation is retired, never pushed back
                        if (slot_gen[idx] != GEN_TOP) begin
                            if (free_depth < SLOTS) begin
                                free_slots[free_depth] = idx;
                                free_depth++;
                            end
                            slot_gen[idx] = slot_gen[idx] + 1'b1;
                        end
                        a.status = gha_pkg::ST_OK;
                    end
                end
                gha_pkg::OP_CHECK: begin
                    if (is_live(idx, g)) a.status = gha_pkg::ST_OK;
                end
                default: begin
                end
            endcase
            a.live = live[LBITS-1:0];
            pending.insert(pending.size(), a);
            return a;
        endfunction

        function void report(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        endfunction

        function void check_result(t_answer got);
            t_answer want;
            if (pending.size() == 0) begin
                report("unexpected result, status", -1, got.status);
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (got.status !== want.status) report("status", want.status, got.status);
            if (got.index !== want.index) report("new_index", want.index, got.index);
            if (got.generation !== want.generation)
                report("new_generation", want.generation, got.generation);
            if (got.live !== want.live) report("live_count", want.live, got.live);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic [1:0]       i_opcode = gha_pkg::OP_CREATE;
    logic [IBITS-1:0] i_handle_index = '0;
    logic [GBITS-1:0] i_handle_generation = '0;
    logic             busy;
    logic             o_valid;
    logic [1:0]       o_status;
    logic [IBITS-1:0] o_new_index;
    logic [GBITS-1:0] o_new_generation;
    logic [LBITS-1:0] o_live_count;

    t_allocator_scoreboard sb;
    bit                    idling_on;
    t_handle               live_handles[$];
    t_handle               dead_handles[$];
    int                    items_sent;
    int                    cycles = 0;

    generational_handle_allocator_unit #(
        .SLOT_COUNT(SLOTS),
        .GEN_BITS  (GBITS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_handle_index     (i_handle_index),
        .i_handle_generation(i_handle_generation),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_new_index        (o_new_index),
        .o_new_generation   (o_new_generation),
        .o_live_count       (o_live_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(t_answer'{o_status, o_new_index, o_new_generation, o_live_count});
    end

    task automatic pause_sender(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results(input int settle);
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic issue(input logic [1:0] op, input t_handle h, output t_answer a);
        bit found;
        if (idling_on && $urandom_range(0, 99) < 9) pause_sender($urandom_range(1, 5));
        start <= 1'b1;
        i_opcode <= op;
        i_handle_index <= h.index;
        i_handle_generation <= h.generation;
        do @(posedge i_clk); while (busy);
        a = sb.note_item(op, h.index, h.generation);
        items_sent++;
        if (a.status == gha_pkg::ST_OK && op == gha_pkg::OP_CREATE) begin
            live_handles.insert(live_handles.size(), t_handle'{a.index, a.generation});
        end else if (a.status == gha_pkg::ST_OK && op == gha_pkg::OP_DESTROY) begin
            found = 1'b0;
            for (int i = 0; i < live_handles.size() && !found; i++) begin
                if (live_handles[i] == h) begin
                    live_handles.delete(i);
                    found = 1'b1;
                end
            end
            dead_handles.insert(dead_handles.size(), h);
            if (dead_handles.size() > 32) dead_handles.delete(0);
        end
    endtask

    task automatic random_item();
        int      pick;
        logic [1:0] op;
        t_handle h;
        t_answer a;
        pick = $urandom_range(0, 99);
        h = t_handle'{IBITS'($urandom_range(0, SLOTS - 1)), GBITS'($urandom)};
        op = $urandom_range(0, 1) ? gha_pkg::OP_DESTROY : gha_pkg::OP_CHECK;
        if (pick < 40) begin
            op = gha_pkg::OP_CREATE;
        end else if (pick < 70 && live_handles.size() > 0) begin
            op = gha_pkg::OP_DESTROY;
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        end else if (pick < 82 && live_handles.size() > 0) begin
            op = gha_pkg::OP_CHECK;
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        end else if (pick < 88 && dead_handles.size() > 0) begin
            h = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
        end else if (pick < 92 && live_handles.size() > 0) begin
            // stale generation on a live slot
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
            h.generation = h.generation ^ GBITS'($urandom_range(1, (1 << GBITS) - 1));
        end else if (pick >= 96) begin
            op = OP_UNUSED;
        end
        issue(op, h, a);
    endtask

    initial begin
        t_answer a;
        t_handle h0;
        t_handle h1;
        sb = new;
        idling_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items
        issue(gha_pkg::OP_CHECK, t_handle'{'0, '0}, a);
        issue(gha_pkg::OP_DESTROY, t_handle'{'1, '1}, a);
        issue(OP_UNUSED, t_handle'{'1, '1}, a);
        issue(gha_pkg::OP_CREATE, t_handle'{'1, '1}, a);
        h0 = t_handle'{a.index, a.generation};
        issue(gha_pkg::OP_CREATE, t_handle'{'0, '0}, a);
        h1 = t_handle'{a.index, a.generation};
        issue(gha_pkg::OP_CHECK, h0, a);
        issue(gha_pkg::OP_CHECK, t_handle'{h0.index, GEN_TOP}, a);
        issue(gha_pkg::OP_CHECK, t_handle'{IBITS'(2), '0}, a);
        issue(gha_pkg::OP_DESTROY, h0, a);
        issue(gha_pkg::OP_DESTROY, h0, a);
        issue(gha_pkg::OP_CHECK, h0, a);
        issue(gha_pkg::OP_CREATE, t_handle'{'0, '0}, a);
        issue(gha_pkg::OP_DESTROY, t_handle'{h1.index, h1.generation + 1'b1}, a);
        issue(OP_UNUSED, h1, a);
        issue(gha_pkg::OP_CHECK, h1, a);
        issue(gha_pkg::OP_DESTROY, h1, a);
        issue(gha_pkg::OP_CREATE, t_handle'{'0, '0}, a);
        issue(gha_pkg::OP_CREATE, t_handle'{'0, '0}, a);
        drain_results(4);

        // random mix with a stretch of back-to-back items, without idle pauses, in the middle
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idling_on = !(n >= 250 && n < 400);
            random_item();
        end
        idling_on = 1'b1;
        drain_results(3);

        // release everything in random order
        while (live_handles.size() > 0) begin
            if ($urandom_range(0, 9) == 0 && dead_handles.size() > 0)
                issue(gha_pkg::OP_CHECK,
                      dead_handles[$urandom_range(0, dead_handles.size() - 1)], a);
            issue(gha_pkg::OP_DESTROY,
                  live_handles[$urandom_range(0, live_handles.size() - 1)], a);
        end
        for (int n = 0; n < 6; n++) random_item();

        drain_results(8);
        $display("covered %0d items: directed cases, %0d random items with slot reuse,",
                 items_sent, RANDOM_ITEMS);
        $display("stale and dead handles, unknown opcodes and release of every slot");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/gha_pkg.sv
rtl/core/gha_ram.sv
rtl/core/generational_handle_allocator_unit.sv
verif/generational_handle_allocator_unit_tb.sv
